// ===== rtl/assert_macros.svh =====
// assertion macros for the rtl files, included by the frame sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define TFG_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define TFG_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/tfg_pkg.sv =====
// shared types, constants and text payload lookup for the telemetry frame generator
package tfg_pkg;

	localparam logic [7:0]  CRC_POLY      = 8'hD5;
	localparam logic [7:0]  TYPE_TEXT     = 8'h21;
	localparam logic [7:0]  TYPE_BATTERY  = 8'h08;
	localparam logic [15:0] RST_TEXT_PER  = 16'd250;
	localparam logic [15:0] RST_BATT_PER  = 16'd5000;
	localparam logic [7:0]  RST_DEST      = 8'hEC;
	localparam logic [15:0] DIV10_MUL     = 16'hCCCD;
	localparam int          DIV10_SHIFT   = 19;

	localparam logic [4:0]  TEXT_LEN_NORMAL = 5'd19;
	localparam logic [4:0]  TEXT_LEN_SPORT  = 5'd18;
	localparam logic [4:0]  BATT_LEN        = 5'd12;

	localparam logic [1:0]  CFG_TEXT_PERIOD = 2'd0;
	localparam logic [1:0]  CFG_BATT_PERIOD = 2'd1;
	localparam logic [1:0]  CFG_DEST        = 2'd2;

	typedef struct packed {
		logic [15:0] text_period;
		logic [15:0] battery_period;
		logic [7:0]  dest;
	} cfg_t;

	function automatic logic [7:0] text_byte(input logic [3:0] idx,
		input logic [1:0] gear_v, input logic sport_v,
		input logic light_v, input logic cam_v);
		logic [3:0] mlen;
		logic [3:0] m;
		logic [3:0] k;
		logic [7:0] b;
		mlen = sport_v ? 4'd5 : 4'd6;
		m = idx - 4'd2;
		k = idx - 4'd2 - mlen;
		b = 8'h00;
		if (idx == 4'd0) begin
			case (gear_v)
				2'd1:    b = "D";
				2'd2:    b = "R";
				default: b = "N";
			endcase
		end else if (idx == 4'd1) begin
			b = "|";
		end else if (m < mlen) begin
			if (sport_v) begin
				case (m)
					4'd0:    b = "S";
					4'd1:    b = "P";
					4'd2:    b = "O";
					4'd3:    b = "R";
					default: b = "T";
				endcase
			end else begin
				case (m)
					4'd0:    b = "N";
					4'd1:    b = "O";
					4'd2:    b = "R";
					4'd3:    b = "M";
					4'd4:    b = "A";
					default: b = "L";
				endcase
			end
		end else begin
			case (k)
				4'd0:    b = "|";
				4'd1:    b = "L";
				4'd2:    b = {7'b0011000, light_v};
				4'd3:    b = "|";
				4'd4:    b = "C";
				4'd5:    b = {7'b0011000, cam_v};
				default: b = 8'h00;
			endcase
		end
		return b;
	endfunction

endpackage

// ===== rtl/tfg_crc8.sv =====
// crc-8 byte step, polynomial 0xd5
module tfg_crc8 (
	input  logic [7:0] crc_in,
	input  logic [7:0] data,
	output logic [7:0] crc_out
);
	import tfg_pkg::*;

	always_comb begin
		logic [7:0] c;
		c = crc_in ^ data;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		crc_out = c;
	end

endmodule

// ===== rtl/tfg_seq.sv =====
// frame sequencer: due check, byte generation, shared crc step and output register
`include "assert_macros.svh"

module tfg_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  tfg_pkg::cfg_t       cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [31:0]         now_ms,
	input  logic [1:0]          gear,
	input  logic                sport_mode,
	input  logic                light_on,
	input  logic                rear_camera_on,
	input  logic [15:0]         battery_millivolts,
	input  logic [7:0]          battery_level,
	input  logic                link_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          out_byte,
	output logic                frame_end,
	output logic                run_last
);
	import tfg_pkg::*;

	typedef enum logic [1:0] {
		IDLE,
		EVAL,
		SEND
	} state_t;

	state_t      state_q;
	logic [31:0] now_q;
	logic [1:0]  gear_q;
	logic        sport_q;
	logic        light_q;
	logic        cam_q;
	logic [15:0] mv_q;
	logic [7:0]  level_q;
	logic        link_q;

	logic [31:0] last_text_q;
	logic [31:0] last_batt_q;
	logic        cur_text_q;
	logic        batt_pend_q;
	logic [4:0]  pos_q;
	logic [7:0]  crc_q;
	logic [12:0] dv_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        frame_end_q;
	logic        run_last_q;

	logic [31:0] prod_c;
	logic        text_due_c;
	logic        batt_due_c;
	logic [4:0]  flen_c;
	logic [3:0]  pidx_c;
	logic [7:0]  fbyte_c;
	logic        last_c;
	logic        crc_en_c;
	logic [7:0]  crc_next_c;
	logic        emit_c;

	assign in_ready  = (state_q == IDLE);
	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign frame_end = frame_end_q;
	assign run_last  = run_last_q;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			now_q   <= now_ms;
			gear_q  <= gear;
			sport_q <= sport_mode;
			light_q <= light_on;
			cam_q   <= rear_camera_on;
			mv_q    <= battery_millivolts;
			level_q <= battery_level;
			link_q  <= link_ready;
		end
	end

	// voltage / 10 by reciprocal multiply
	assign prod_c = {16'b0, mv_q} * {16'b0, DIV10_MUL};

	assign text_due_c = (last_text_q == 32'd0) ||
		((now_q - last_text_q) >= {16'b0, cfg.text_period});
	assign batt_due_c = (last_batt_q == 32'd0) ||
		((now_q - last_batt_q) >= {16'b0, cfg.battery_period});

	assign flen_c   = cur_text_q ? (sport_q ? TEXT_LEN_SPORT : TEXT_LEN_NORMAL) : BATT_LEN;
	assign pidx_c   = 4'(pos_q - 5'd3);
	assign last_c   = (pos_q == flen_c - 5'd1);
	assign crc_en_c = (pos_q >= 5'd2) && !last_c;
	assign emit_c   = !out_valid_q || out_ready;

	always_comb begin
		fbyte_c = 8'h00;
		if (pos_q == 5'd0) begin
			fbyte_c = cfg.dest;
		end else if (pos_q == 5'd1) begin
			fbyte_c = {3'b0, flen_c - 5'd2};
		end else if (pos_q == 5'd2) begin
			fbyte_c = cur_text_q ? TYPE_TEXT : TYPE_BATTERY;
		end else if (last_c) begin
			fbyte_c = crc_q;
		end else if (cur_text_q) begin
			fbyte_c = text_byte(pidx_c, gear_q, sport_q, light_q, cam_q);
		end else begin
			case (pidx_c)
				4'd0:    fbyte_c = {3'b0, dv_q[12:8]};
				4'd1:    fbyte_c = dv_q[7:0];
				4'd7:    fbyte_c = level_q;
				default: fbyte_c = 8'h00;
			endcase
		end
	end

	tfg_crc8 u_crc (
		.crc_in  (crc_q),
		.data    (fbyte_c),
		.crc_out (crc_next_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			last_text_q <= 32'd0;
			last_batt_q <= 32'd0;
			cur_text_q  <= 1'b0;
			batt_pend_q <= 1'b0;
			pos_q       <= 5'd0;
			crc_q       <= 8'd0;
			dv_q        <= 13'd0;
			out_valid_q <= 1'b0;
			out_byte_q  <= 8'd0;
			frame_end_q <= 1'b0;
			run_last_q  <= 1'b0;
		end else begin
			// in SEND a taken byte is replaced by the next one below
			if (out_valid_q && out_ready && (state_q != SEND)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (in_valid) begin
						state_q <= EVAL;
					end
				end
				EVAL: begin
					pos_q       <= 5'd0;
					crc_q       <= 8'd0;
					dv_q        <= prod_c[31:DIV10_SHIFT];
					cur_text_q  <= text_due_c;
					batt_pend_q <= text_due_c && batt_due_c;
					if (link_q && (text_due_c || batt_due_c)) begin
						state_q <= SEND;
						if (text_due_c) begin
							last_text_q <= now_q;
						end
						if (batt_due_c) begin
							last_batt_q <= now_q;
						end
					end else begin
						state_q <= IDLE;
					end
				end
				SEND: begin
					if (emit_c) begin
						out_valid_q <= 1'b1;
						out_byte_q  <= fbyte_c;
						frame_end_q <= last_c;
						run_last_q  <= last_c && !batt_pend_q;
						if (crc_en_c) begin
							crc_q <= crc_next_c;
						end
						if (last_c) begin
							if (batt_pend_q) begin
								cur_text_q  <= 1'b0;
								batt_pend_q <= 1'b0;
								pos_q       <= 5'd0;
								crc_q       <= 8'd0;
							end else begin
								state_q <= IDLE;
							end
						end else begin
							pos_q <= pos_q + 5'd1;
						end
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	`TFG_ASSERT_IMP(a_run_last_ends_frame, out_valid_q && run_last_q, frame_end_q, "run_last off crc")
	`TFG_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after item")
	`TFG_ASSERT_IMP(a_batt_pend_only_text, state_q == SEND && !cur_text_q, !batt_pend_q, "stray pend")
	`TFG_ASSERT_IMP(a_pos_in_frame, state_q == SEND, pos_q < flen_c, "byte index past frame end")

endmodule

// ===== rtl/telemetry_frame_generator.sv =====
// top level: configuration registers and frame sequencer
//
// channel  direction  handshake              payload
// in       sink       in_valid / in_ready    now_ms .. link_ready
// out      source     out_valid / out_ready  out_byte, frame_end, run_last
// cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// an item is captured in IDLE and due-checked in EVAL, then sent at one frame byte per cycle
// (0, 12, 18, 19, 30 or 31 bytes), paced by the single byte output register
// in_ready is high only while the sequencer is idle; out_ready low holds the sequencer
// asynchronous reset clears times to never sent and loads the register defaults
// cfg writes are always taken, as cfg_ready is tied high
module telemetry_frame_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] now_ms,
	input  logic [1:0]  gear,
	input  logic        sport_mode,
	input  logic        light_on,
	input  logic        rear_camera_on,
	input  logic [15:0] battery_millivolts,
	input  logic [7:0]  battery_level,
	input  logic        link_ready,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        frame_end,
	output logic        run_last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import tfg_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.text_period    <= RST_TEXT_PER;
			cfg_q.battery_period <= RST_BATT_PER;
			cfg_q.dest           <= RST_DEST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TEXT_PERIOD: cfg_q.text_period    <= cfg_data;
				CFG_BATT_PERIOD: cfg_q.battery_period <= cfg_data;
				CFG_DEST:        cfg_q.dest           <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	tfg_seq u_seq (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg                (cfg_q),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.now_ms             (now_ms),
		.gear               (gear),
		.sport_mode         (sport_mode),
		.light_on           (light_on),
		.rear_camera_on     (rear_camera_on),
		.battery_millivolts (battery_millivolts),
		.battery_level      (battery_level),
		.link_ready         (link_ready),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.out_byte           (out_byte),
		.frame_end          (frame_end),
		.run_last           (run_last)
	);

endmodule

// ===== tb/telemetry_frame_generator_test.sv =====
// self-checking testbench for telemetry_frame_generator: scoreboard with frame predictor
`timescale 1ns / 1ps

module telemetry_frame_generator_test;
	import tfg_pkg::*;

	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_LIMIT = 50000;
	localparam int TAIL_CYCLES = 40;
	localparam int ITEMS_PER_PHASE = 120;

	typedef struct {
		logic [31:0] now;
		logic [1:0]  gear;
		logic        sport;
		logic        light;
		logic        cam;
		logic [15:0] mv;
		logic [7:0]  level;
		logic        ready;
	} status_sample_t;

	typedef struct {
		logic [7:0] data;
		logic       frame_end;
		logic       run_last;
	} frame_byte_t;

	class telemetry_scoreboard;
		logic [15:0] text_period;
		logic [15:0] battery_period;
		logic [7:0]  dest;
		logic [31:0] last_text;
		logic [31:0] last_battery;
		logic [7:0]  body[$];
		frame_byte_t pending[$];
		int errors;
		int samples;
		int results;
		int text_frames;
		int battery_frames;

		function new();
			text_period = RST_TEXT_PER;
			battery_period = RST_BATT_PER;
			dest = RST_DEST;
			last_text = '0;
			last_battery = '0;
			errors = 0;
			samples = 0;
			results = 0;
			text_frames = 0;
			battery_frames = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [15:0] data);
			case (idx)
				CFG_TEXT_PERIOD: text_period = data;
				CFG_BATT_PERIOD: battery_period = data;
				CFG_DEST:        dest = data[7:0];
				default: ;
			endcase
		endfunction

		function logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] b);
			logic [7:0] c;
			c = crc ^ b;
			repeat (8) c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
			return c;
		endfunction

		function void push_byte(logic [7:0] b, logic fe);
			frame_byte_t e;
			e.data = b;
			e.frame_end = fe;
			e.run_last = 1'b0;
			pending.push_back(e);
		endfunction

		// header, body and crc over type and body
		function void queue_frame(logic [7:0] kind);
			logic [7:0] crc;
			push_byte(dest, 1'b0);
			push_byte(8'(body.size() + 2), 1'b0);
			push_byte(kind, 1'b0);
			crc = crc8_step(8'h00, kind);
			foreach (body[i]) begin
				crc = crc8_step(crc, body[i]);
				push_byte(body[i], 1'b0);
			end
			push_byte(crc, 1'b1);
		endfunction

		function void note_sample(status_sample_t s);
			logic [31:0] text_elapsed;
			logic [31:0] battery_elapsed;
			logic text_due;
			logic battery_due;
			logic [15:0] tenths;
			string mode;
			int first;
			frame_byte_t e;
			samples++;
			text_elapsed = s.now - last_text;
			battery_elapsed = s.now - last_battery;
			text_due = (last_text == 0) || (text_elapsed >= {16'h0, text_period});
			battery_due = (last_battery == 0) || (battery_elapsed >= {16'h0, battery_period});
			if (!s.ready)
				return;
			first = pending.size();
			if (text_due) begin
				body.delete();
				body.push_back(s.gear == 2'd1 ? "D" : (s.gear == 2'd2 ? "R" : "N"));
				body.push_back("|");
				mode = s.sport ? "SPORT" : "NORMAL";
				for (int i = 0; i < mode.len(); i++)
					body.push_back(mode[i]);
				body.push_back("|");
				body.push_back("L");
				body.push_back("0" | {7'b0, s.light});
				body.push_back("|");
				body.push_back("C");
				body.push_back("0" | {7'b0, s.cam});
				body.push_back(8'h00);
				queue_frame(TYPE_TEXT);
				last_text = s.now;
				text_frames++;
			end
			if (battery_due) begin
				tenths = s.mv / 16'd10;
				body.delete();
				body.push_back(tenths[15:8]);
				body.push_back(tenths[7:0]);
				repeat (5) body.push_back(8'h00);
				body.push_back(s.level);
				queue_frame(TYPE_BATTERY);
				last_battery = s.now;
				battery_frames++;
			end
			if (pending.size() > first) begin
				e = pending.pop_back();
				e.run_last = 1'b1;
				pending.push_back(e);
			end
		endfunction

		function void check_byte(logic [7:0] b, logic fe, logic rl);
			frame_byte_t e;
			results++;
			if (pending.size() == 0) begin
				$error("unexpected item: out_byte %0h frame_end %0b run_last %0b", b, fe, rl);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (b !== e.data) begin
				$error("out_byte: expected %0h, got %0h", e.data, b);
				errors++;
			end
			if (fe !== e.frame_end) begin
				$error("frame_end: expected %0b, got %0b", e.frame_end, fe);
				errors++;
			end
			if (rl !== e.run_last) begin
				$error("run_last: expected %0b, got %0b", e.run_last, rl);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] now_ms;
	logic [1:0]  gear;
	logic        sport_mode;
	logic        light_on;
	logic        rear_camera_on;
	logic [15:0] battery_millivolts;
	logic [7:0]  battery_level;
	logic        link_ready;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  out_byte;
	logic        frame_end;
	logic        run_last;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	telemetry_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int holds_asked = 0;
	int reg_batches = 0;
	logic [31:0] clock_ms = '0;

	telemetry_frame_generator dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.now_ms(now_ms),
		.gear(gear),
		.sport_mode(sport_mode),
		.light_on(light_on),
		.rear_camera_on(rear_camera_on),
		.battery_millivolts(battery_millivolts),
		.battery_level(battery_level),
		.link_ready(link_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.frame_end(frame_end),
		.run_last(run_last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// receiver: random stalls, plus long hold-offs on request
	initial begin
		int holds_done;
		holds_done = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (holds_done < holds_asked) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_done++;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_byte(out_byte, frame_end, run_last);
	end

	function automatic status_sample_t make_sample(logic [31:0] t, logic [1:0] g, logic sp,
		logic li, logic ca, logic [15:0] mv, logic [7:0] lv, logic rdy);
		status_sample_t s;
		s.now = t;
		s.gear = g;
		s.sport = sp;
		s.light = li;
		s.cam = ca;
		s.mv = mv;
		s.level = lv;
		s.ready = rdy;
		return s;
	endfunction

	// mostly a running clock stepped around the periods, some unrelated times
	function automatic status_sample_t random_sample();
		status_sample_t s;
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 2) begin
			s.now = $urandom;
			s.ready = 1'($urandom_range(0, 1));
		end else begin
			if (pick < 11)
				clock_ms += $urandom_range(0, 2 * int'(sb.text_period) + 2);
			else if (pick < 16)
				clock_ms += $urandom_range(0, 2 * int'(sb.battery_period) + 2);
			else if (pick == 16)
				clock_ms += $urandom;
			s.now = clock_ms;
			s.ready = ($urandom_range(0, 7) != 0);
		end
		s.gear = 2'($urandom);
		s.sport = 1'($urandom);
		s.light = 1'($urandom);
		s.cam = 1'($urandom);
		s.mv = 16'($urandom);
		s.level = 8'($urandom);
		return s;
	endfunction

	task automatic send_sample(status_sample_t s);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		now_ms <= s.now;
		gear <= s.gear;
		sport_mode <= s.sport;
		light_on <= s.light;
		rear_camera_on <= s.cam;
		battery_millivolts <= s.mv;
		battery_level <= s.level;
		link_ready <= s.ready;
		do @(posedge clk); while (!in_ready);
		sb.note_sample(s);
	endtask

	task automatic wait_drained();
		int n;
		n = 0;
		while (sb.pending.size() != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		if (sb.pending.size() != 0) begin
			$error("%0d expected items never arrived", sb.pending.size());
			sb.errors++;
			sb.pending.delete();
		end
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic end_batch();
		in_valid <= 1'b0;
		wait_drained();
	endtask

	task automatic program_regs(logic [15:0] tp, logic [15:0] bp, logic [15:0] dd);
		logic [1:0]  idx[4];
		logic [15:0] val[4];
		idx = '{CFG_TEXT_PERIOD, CFG_BATT_PERIOD, CFG_DEST, CFG_UNUSED};
		val = '{tp, bp, dd, 16'($urandom)};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			do @(posedge clk); while (!cfg_ready);
			sb.write_reg(idx[i], val[i]);
		end
		cfg_valid <= 1'b0;
		reg_batches++;
	endtask

	task automatic run_phase(int idle, int stall, bit hold);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		if (hold)
			holds_asked++;
		repeat (ITEMS_PER_PHASE) send_sample(random_sample());
		end_batch();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		now_ms = '0;
		gear = '0;
		sport_mode = 1'b0;
		light_on = 1'b0;
		rear_camera_on = 1'b0;
		battery_millivolts = '0;
		battery_level = '0;
		link_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset periods: first send, time zero, link down, nothing due, wrap
		send_sample(make_sample(32'd0, 2'd0, 1'b0, 1'b0, 1'b0, 16'd0, 8'd0, 1'b1));
		send_sample(make_sample(32'd100, 2'd1, 1'b0, 1'b0, 1'b0, 16'd5, 8'd3, 1'b0));
		send_sample(make_sample(32'd100, 2'd1, 1'b1, 1'b1, 1'b0, 16'd9, 8'd1, 1'b1));
		send_sample(make_sample(32'd200, 2'd0, 1'b0, 1'b0, 1'b1, 16'd100, 8'd50, 1'b1));
		send_sample(make_sample(32'd350, 2'd2, 1'b0, 1'b1, 1'b1, 16'd10, 8'd7, 1'b1));
		send_sample(make_sample(32'd5100, 2'd3, 1'b1, 1'b0, 1'b1, 16'hFFFF, 8'hFF, 1'b1));
		send_sample(make_sample(32'd5101, 2'd1, 1'b0, 1'b1, 1'b0, 16'd12345, 8'd80, 1'b1));
		send_sample(make_sample(32'hFFFF_FFFF, 2'd0, 1'b1, 1'b1, 1'b1, 16'd0, 8'd0, 1'b1));
		send_sample(make_sample(32'h0000_00F9, 2'd2, 1'b1, 1'b0, 1'b0, 16'd3300, 8'd42, 1'b1));
		send_sample(make_sample(32'h0000_00FA, 2'd3, 1'b0, 1'b0, 1'b0, 16'd3300, 8'd42, 1'b0));
		end_batch();

		// zero periods: due on every sample; dest takes the low byte only
		program_regs(16'd0, 16'd0, 16'hAB12);
		send_sample(make_sample(32'h0000_00FA, 2'd1, 1'b0, 1'b1, 1'b1, 16'd4200, 8'd99, 1'b1));
		send_sample(make_sample(32'h0000_00FA, 2'd2, 1'b1, 1'b0, 1'b1, 16'd65530, 8'd100, 1'b1));
		send_sample(make_sample(32'd0, 2'd0, 1'b0, 1'b1, 1'b0, 16'd11, 8'd128, 1'b1));
		send_sample(make_sample(32'd5, 2'd3, 1'b1, 1'b1, 1'b1, 16'd19, 8'd127, 1'b1));
		end_batch();

		program_regs(16'd1, 16'hFFFF, 16'h00FF);
		send_sample(make_sample(32'd5, 2'd1, 1'b1, 1'b0, 1'b0, 16'd7400, 8'd64, 1'b1));
		send_sample(make_sample(32'd5, 2'd1, 1'b1, 1'b0, 1'b0, 16'd7400, 8'd64, 1'b1));
		send_sample(make_sample(32'd6, 2'd2, 1'b0, 1'b1, 1'b0, 16'd7399, 8'd63, 1'b1));
		send_sample(make_sample(32'd65540, 2'd0, 1'b0, 1'b0, 1'b1, 16'd8000, 8'd2, 1'b1));
		send_sample(make_sample(32'd131074, 2'd3, 1'b1, 1'b1, 1'b0, 16'd8001, 8'd1, 1'b1));
		send_sample(make_sample(32'd200000, 2'd1, 1'b0, 1'b0, 1'b0, 16'd1, 8'd0, 1'b0));
		end_batch();

		clock_ms = 32'd200000;
		program_regs(16'hFFFF, 16'd1, 16'hFFFF);
		run_phase(0, 0, 1'b0);
		program_regs(16'($urandom_range(1, 300)), 16'($urandom_range(1, 3000)), 16'($urandom));
		run_phase(73, 0, 1'b0);
		program_regs(16'd10, 16'd50, 16'hFF00);
		run_phase(0, 73, 1'b1);
		program_regs(16'($urandom_range(0, 500)), 16'($urandom_range(0, 5000)), 16'($urandom));
		run_phase(38, 38, 1'b0);

		$display("%0d status items in, %0d frame bytes checked (%0d text, %0d battery frames)",
			sb.samples, sb.results, sb.text_frames, sb.battery_frames);
		$display("%0d register settings, idle mixes none/sender/receiver/both, one long hold-off",
			reg_batches);
		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/tfg_pkg.sv
rtl/tfg_crc8.sv
rtl/tfg_seq.sv
rtl/telemetry_frame_generator.sv
tb/telemetry_frame_generator_test.sv
